### rtl/core/sorted_top_k_insert_core_macros.svh
// Assertion macros for the top-k insertion core and its port checker.
// Included by the checker only; depends on nothing else.
`ifndef SORTED_TOP_K_INSERT_CORE_MACROS_SVH
`define SORTED_TOP_K_INSERT_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define STK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stk assertion failed");

// Next-cycle implication, off while reset is asserted.
`define STK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stk assertion failed");

`endif

### rtl/core/stk_pkg.sv
// Shared types, constants and helpers for the top-k insertion core.
// No dependencies; imported by every module of the core.
`default_nettype none

package stk_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int VAL_W       = 64;
    localparam int POS_W       = 5;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 4;
    localparam int CFG_DATA_W  = 5;

    localparam logic [POS_W-1:0] NO_POS      = POS_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_RESET   = CNT_W'(16);
    localparam logic [VAL_W-1:0] SIGN_BIT    = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NOP    = 2'd3
    } t_req_type;

    typedef enum logic {
        CFG_KEEP_LARGEST   = 1'b0,
        CFG_ENTRIES_IN_USE = 1'b1
    } t_cfg_index;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic clr;
        logic keep_largest;
    } t_cell_cmd;

    // What one cell hands to the next
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] high;
        logic [VAL_W-1:0] low;
    } t_link;

    function automatic logic [VAL_W-1:0] sentinel_high(input logic keep_largest);
        return keep_largest ? SIGN_BIT : ~SIGN_BIT;
    endfunction

    function automatic logic [VAL_W-1:0] sentinel_low(input logic keep_largest);
        return keep_largest ? {VAL_W{1'b0}} : {VAL_W{1'b1}};
    endfunction

    // Signed 128-bit a < b
    function automatic logic less128(input logic [VAL_W-1:0] a_high,
                                     input logic [VAL_W-1:0] a_low,
                                     input logic [VAL_W-1:0] b_high,
                                     input logic [VAL_W-1:0] b_low);
        return $signed({a_high, a_low}) < $signed({b_high, b_low});
    endfunction

endpackage

`default_nettype wire

### rtl/core/stk_cell.sv
// One cell of the insertion row: holds a 128-bit entry, compares it with the
// request value and passes its entry and the found flag on. Uses stk_pkg.
`default_nettype none

module stk_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire stk_pkg::t_cell_cmd       i_cmd,
    input  wire                           i_in_use,
    input  wire  [stk_pkg::VAL_W-1:0]     i_value_high,
    input  wire  [stk_pkg::VAL_W-1:0]     i_value_low,
    input  wire stk_pkg::t_link           i_prev,
    output stk_pkg::t_link                o_next,
    output logic                          o_insert_here
);
    import stk_pkg::*;

    logic [VAL_W-1:0] r_high;
    logic [VAL_W-1:0] r_low;
    logic [VAL_W-1:0] n_high;
    logic [VAL_W-1:0] n_low;
    logic [VAL_W-1:0] w_a_high;
    logic [VAL_W-1:0] w_a_low;
    logic [VAL_W-1:0] w_b_high;
    logic [VAL_W-1:0] w_b_low;
    logic             w_beat;

    // Swap the operands so one comparator serves both modes
    always_comb begin
        if (i_cmd.keep_largest) begin
            w_a_high = r_high;
            w_a_low  = r_low;
            w_b_high = i_value_high;
            w_b_low  = i_value_low;
        end else begin
            w_a_high = i_value_high;
            w_a_low  = i_value_low;
            w_b_high = r_high;
            w_b_low  = r_low;
        end
        w_beat = i_in_use & less128(w_a_high, w_a_low, w_b_high, w_b_low);
    end

    assign o_insert_here = i_cmd.ins & ~i_prev.found & w_beat;
    assign o_next.found  = i_prev.found | w_beat;
    assign o_next.high   = r_high;
    assign o_next.low    = r_low;

    always_comb begin
        n_high = r_high;
        n_low  = r_low;
        if (i_cmd.clr) begin
            n_high = sentinel_high(i_cmd.keep_largest);
            n_low  = sentinel_low(i_cmd.keep_largest);
        end else if (i_cmd.ins && i_in_use) begin
            if (i_prev.found) begin
                // shift down from the neighbour
                n_high = i_prev.high;
                n_low  = i_prev.low;
            end else if (w_beat) begin
                n_high = i_value_high;
                n_low  = i_value_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= sentinel_high(1'b0);
            r_low  <= sentinel_low(1'b0);
        end else begin
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sorted_top_k_insert_core.sv
// Top level of the top-k insertion core: a row of stk_cell entries, the
// configuration registers and the result register. Uses stk_pkg, stk_cell.
//
// Keeps a sorted list of the best signed 128-bit values in a row of cells, one
// entry per cell. Insert, read, clear and no-op requests are taken one per
// clock cycle and each gives one result on the next cycle; the request is
// applied to the whole row in the cycle it is accepted. The rate is set by the
// per-cell 128-bit comparator and the found chain that runs along the row. The
// result register holds a result while the output side stalls, and the input
// side is stalled only while that result is held. Configuration writes are
// always ready and take effect on the next request.
`default_nettype none

module sorted_top_k_insert_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [1:0]                         i_req_type,
    input  wire  signed [stk_pkg::VAL_W-1:0]   i_value_high,
    input  wire  [stk_pkg::VAL_W-1:0]          i_value_low,
    input  wire  [stk_pkg::IDX_W-1:0]          i_read_index,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_was_inserted,
    output logic [stk_pkg::POS_W-1:0]          o_insert_position,
    output logic signed [stk_pkg::VAL_W-1:0]   o_read_high,
    output logic [stk_pkg::VAL_W-1:0]          o_read_low,
    // configuration channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire                                i_cfg_index,
    input  wire  [stk_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import stk_pkg::*;

    logic             r_keep_largest;
    logic [CNT_W-1:0] r_entries_in_use;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_was_inserted;
    logic [POS_W-1:0] r_insert_position;
    logic [VAL_W-1:0] r_read_high;
    logic [VAL_W-1:0] r_read_low;

    logic             w_accept;
    t_req_type        w_req;
    t_cell_cmd        w_cmd;
    t_link            w_link [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_in_use;
    logic [MAX_ENTRIES-1:0] w_insert_here;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_rd_high;
    logic [VAL_W-1:0] w_rd_low;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_req       = t_req_type'(i_req_type);
    assign o_cfg_ready = 1'b1;

    assign w_cmd.ins          = w_accept && (w_req == REQ_INSERT);
    assign w_cmd.clr          = w_accept && (w_req == REQ_CLEAR);
    assign w_cmd.keep_largest = r_keep_largest;

    assign w_link[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign w_in_use[g] = 32'(r_entries_in_use) > g;

        stk_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_in_use      (w_in_use[g]),
            .i_value_high  (i_value_high),
            .i_value_low   (i_value_low),
            .i_prev        (w_link[g]),
            .o_next        (w_link[g+1]),
            .o_insert_here (w_insert_here[g])
        );
    end

    // At most one cell claims the insert point, so OR its index out
    always_comb begin
        w_pos     = '0;
        w_rd_high = '0;
        w_rd_low  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_insert_here[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
            if (32'(i_read_index) == i) begin
                w_rd_high = w_rd_high | w_link[i+1].high;
                w_rd_low  = w_rd_low | w_link[i+1].low;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_keep_largest   <= 1'b0;
            r_entries_in_use <= CNT_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_KEEP_LARGEST:   r_keep_largest   <= i_cfg_data[0];
                    CFG_ENTRIES_IN_USE: r_entries_in_use <= CNT_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_was_inserted    <= |w_insert_here;
            r_insert_position <= (|w_insert_here) ? w_pos : NO_POS;
            if (w_req == REQ_READ) begin
                r_read_high <= w_rd_high;
                r_read_low  <= w_rd_low;
            end else begin
                r_read_high <= '0;
                r_read_low  <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_was_inserted    = r_was_inserted;
    assign o_insert_position = r_insert_position;
    assign o_read_high       = $signed(r_read_high);
    assign o_read_low        = r_read_low;

endmodule

`default_nettype wire

### rtl/core/stk_checker.sv
// Port checker for the top-k insertion core, bound to the top level.
// Uses stk_pkg and sorted_top_k_insert_core_macros.svh.
`default_nettype none
`include "sorted_top_k_insert_core_macros.svh"

module stk_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire                          o_was_inserted,
    input wire [stk_pkg::POS_W-1:0]     o_insert_position,
    input wire [stk_pkg::VAL_W-1:0]     o_read_high,
    input wire [stk_pkg::VAL_W-1:0]     o_read_low
);
    import stk_pkg::*;

    `STK_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `STK_ASSERT_NEXT(a_request_answered, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid)
    `STK_ASSERT_IMPLY(a_pos_in_range, i_clk, i_rst_n, o_out_valid && o_was_inserted, 32'(o_insert_position) < MAX_ENTRIES)
    `STK_ASSERT_IMPLY(a_pos_rejected, i_clk, i_rst_n, o_out_valid && !o_was_inserted, o_insert_position == NO_POS)
    `STK_ASSERT_IMPLY(a_insert_no_read, i_clk, i_rst_n, o_out_valid && o_was_inserted, o_read_high == '0 && o_read_low == '0)

endmodule

bind sorted_top_k_insert_core stk_checker u_stk_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for sorted_top_k_insert_core: a directed table, then random request
// segments under varied idling and register settings, each result checked against a predictor
// or a pinned outcome. Depends on stk_pkg and sorted_top_k_insert_core only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stk_pkg::*;

    localparam int          TX_GAP_MAX  = 30;
    localparam int          HOLD_CYCLES = 80;
    localparam int          SEG_ITEMS   = 70;
    localparam int          SEGMENTS    = 12;
    localparam int          TAIL_CYCLES = 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] ONES        = '1;
    localparam logic [63:0] TOP_H       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BOT_H       = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic             ins;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] rh;
        logic [VAL_W-1:0] rl;
    } t_outcome;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_req_type   req;
        logic [63:0] vh;
        logic [63:0] vl;
        logic [3:0]  idx;
        bit          pinned;
        t_outcome    want;
        t_cfg_index  reg_ix;
        logic [4:0]  reg_data;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [1:0]           i_req_type   = REQ_NOP;
    logic signed [63:0]   i_value_high = '0;
    logic [63:0]          i_value_low  = '0;
    logic [3:0]           i_read_index = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 i_cfg_index  = CFG_KEEP_LARGEST;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_was_inserted;
    logic [POS_W-1:0]     o_insert_position;
    logic signed [63:0]   o_read_high;
    logic [63:0]          o_read_low;
    logic                 o_cfg_ready;

    // predictor state
    logic [63:0] best_hi [MAX_ENTRIES];
    logic [63:0] best_lo [MAX_ENTRIES];
    logic        largest_mode;
    logic [4:0]  slots_used;

    t_row     rows[$];
    t_row     pending_q[$];
    t_outcome expected_q[$];

    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 79;
    int          hold_asked  = 0;
    int          hold_served = 0;
    int          cycles      = 0;
    int          fail_count  = 0;
    int          n_placed    = 0;
    int          n_rejected  = 0;
    int          n_reads     = 0;
    int          n_clears    = 0;
    int          n_nops      = 0;
    int          n_cfg       = 0;

    sorted_top_k_insert_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_value_high      (i_value_high),
        .i_value_low       (i_value_low),
        .i_read_index      (i_read_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_was_inserted    (o_was_inserted),
        .o_insert_position (o_insert_position),
        .o_read_high       (o_read_high),
        .o_read_low        (o_read_low),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // signed 128-bit a < b, high halves signed, low halves unsigned
    function automatic bit below(input logic [63:0] ah, input logic [63:0] al,
                                 input logic [63:0] bh, input logic [63:0] bl);
        if (ah != bh)
            return $signed(ah) < $signed(bh);
        return al < bl;
    endfunction

    function automatic void fill_list();
        int k;
        for (k = 0; k < MAX_ENTRIES; k++) begin
            best_hi[k] = largest_mode ? BOT_H : TOP_H;
            best_lo[k] = largest_mode ? 64'd0 : ONES;
        end
    endfunction

    function automatic t_outcome outcome(input logic ins, input logic [4:0] pos,
                                         input logic [63:0] rh, input logic [63:0] rl);
        t_outcome r;
        r.ins = ins;
        r.pos = pos;
        r.rh  = rh;
        r.rl  = rl;
        return r;
    endfunction

    function automatic t_outcome apply_request(input t_req_type req, input logic [63:0] vh,
                                               input logic [63:0] vl, input logic [3:0] idx);
        t_outcome r;
        int       n;
        int       k;
        int       j;
        bit       done;
        r = outcome(1'b0, NO_POS, '0, '0);
        case (req)
            REQ_INSERT: begin
                n    = (slots_used > MAX_ENTRIES) ? MAX_ENTRIES : int'(slots_used);
                done = 0;
                for (k = 0; k < n && !done; k++) begin
                    if (largest_mode ? below(best_hi[k], best_lo[k], vh, vl)
                                     : below(vh, vl, best_hi[k], best_lo[k])) begin
                        // shift the tail down, the last in-use entry falls off
                        for (j = n - 1; j > k; j--) begin
                            best_hi[j] = best_hi[j-1];
                            best_lo[j] = best_lo[j-1];
                        end
                        best_hi[k] = vh;
                        best_lo[k] = vl;
                        r.ins      = 1'b1;
                        r.pos      = POS_W'(k);
                        done       = 1;
                    end
                end
            end
            REQ_READ: begin
                r.rh = best_hi[idx];
                r.rl = best_lo[idx];
            end
            REQ_CLEAR: fill_list();
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // take an accepted request into the predictor
    always @(posedge i_clk) begin : take_request
        t_outcome r;
        t_row     it;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r  = apply_request(t_req_type'(i_req_type), i_value_high, i_value_low,
                               i_read_index);
            it = pending_q.pop_front();
            case (t_req_type'(i_req_type))
                REQ_INSERT: if (r.ins) n_placed++; else n_rejected++;
                REQ_READ:   n_reads++;
                REQ_CLEAR:  n_clears++;
                default:    n_nops++;
            endcase
            expected_q.push_back(it.pinned ? it.want : r);
        end
    end

    always @(posedge i_clk) begin : take_register
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            n_cfg++;
            if (t_cfg_index'(i_cfg_index) == CFG_KEEP_LARGEST)
                largest_mode = i_cfg_data[0];
            else
                slots_used = i_cfg_data;
        end
    end

    always @(posedge i_clk) begin : check_result
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_was_inserted, o_insert_position, o_read_high, o_read_low};
            if (expected_q.size() == 0) begin
                note_failure($sformatf("result with none pending: ins=%0b pos=%0d hi=%h lo=%h",
                                       got.ins, got.pos, got.rh, got.rl));
            end else begin
                want = expected_q.pop_front();
                if (got.ins !== want.ins || got.pos !== want.pos ||
                    got.rh !== want.rh || got.rl !== want.rl)
                    note_failure($sformatf(
                        "want ins=%0b pos=%0d hi=%h lo=%h, got ins=%0b pos=%0d hi=%h lo=%h",
                        want.ins, want.pos, want.rh, want.rl,
                        got.ins, got.pos, got.rh, got.rl));
            end
        end
    end

    // output side: random stall, or a long hold-off when one is asked for
    initial begin : rx_side
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic t_row make_row(input t_req_type r, input logic [63:0] vh,
                                      input logic [63:0] vl, input logic [3:0] ix);
        t_row it;
        it.kind     = ROW_REQ;
        it.req      = r;
        it.vh       = vh;
        it.vl       = vl;
        it.idx      = ix;
        it.pinned   = 0;
        it.want     = '0;
        it.reg_ix   = CFG_KEEP_LARGEST;
        it.reg_data = '0;
        return it;
    endfunction

    task automatic add_req(input t_req_type r, input logic [63:0] vh, input logic [63:0] vl,
                           input logic [3:0] ix);
        rows.push_back(make_row(r, vh, vl, ix));
    endtask

    task automatic add_pinned(input t_req_type r, input logic [63:0] vh, input logic [63:0] vl,
                              input logic [3:0] ix, input t_outcome w);
        t_row it;
        it        = make_row(r, vh, vl, ix);
        it.pinned = 1;
        it.want   = w;
        rows.push_back(it);
    endtask

    task automatic add_cfg(input t_cfg_index ix, input logic [4:0] d);
        t_row it;
        it          = make_row(REQ_NOP, '0, '0, '0);
        it.kind     = ROW_CFG;
        it.reg_ix   = ix;
        it.reg_data = d;
        rows.push_back(it);
    endtask

    function automatic t_row random_request();
        t_row              it;
        int unsigned       sel;
        int unsigned       k;
        logic [127:0]      wide;
        it  = make_row(REQ_INSERT, {$urandom, $urandom}, {$urandom, $urandom},
                       4'($urandom_range(15)));
        sel = $urandom_range(99);
        if (sel >= 95)      it.req = REQ_NOP;
        else if (sel >= 92) it.req = REQ_CLEAR;
        else if (sel >= 75) it.req = REQ_READ;
        if (it.req == REQ_INSERT) begin
            sel = $urandom_range(99);
            k   = $urandom_range(MAX_ENTRIES - 1);
            if (sel < 25) begin
                // keep the fully random value
            end else if (sel < 45) begin
                it.vh = best_hi[k];
                it.vl = best_lo[k];
            end else if (sel < 70) begin
                wide = {best_hi[k], best_lo[k]};
                if ($urandom_range(1)) wide = wide + 128'($urandom_range(1, 3));
                else                   wide = wide - 128'($urandom_range(1, 3));
                {it.vh, it.vl} = wide;
            end else if (sel < 90) begin
                // crowd values around zero so the list fills with near ties
                case ($urandom_range(2))
                    0:       it.vh = ONES;
                    1:       it.vh = '0;
                    default: it.vh = 64'd1;
                endcase
                it.vl = 64'($urandom_range(7));
                if ($urandom_range(1)) it.vl = ~it.vl;
            end else begin
                case ($urandom_range(3))
                    0:       begin it.vh = TOP_H; it.vl = ONES; end
                    1:       begin it.vh = BOT_H; it.vl = '0;   end
                    2:       begin it.vh = '0;    it.vl = '0;   end
                    default: begin it.vh = ONES;  it.vl = ONES; end
                endcase
            end
        end
        return it;
    endfunction

    // offer one request, with an optional gap first; returns on the accepting edge
    task automatic send_item(input t_row it);
        int gap;
        gap = 0;
        while (gap < TX_GAP_MAX && tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        pending_q.push_back(it);
        i_in_valid   <= 1'b1;
        i_req_type   <= it.req;
        i_value_high <= it.vh;
        i_value_low  <= it.vl;
        i_read_index <= it.idx;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0 || pending_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index ix, input logic [4:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : main
        int   seg;
        int   n;
        t_row it;
        logic [4:0] used;

        largest_mode = 1'b0;
        slots_used   = CNT_RESET;
        fill_list();

        // reset contents, extremes and ties in ascending mode
        add_pinned(REQ_READ,   ONES, ONES, 4'd0,  outcome(1'b0, NO_POS, TOP_H, ONES));
        add_pinned(REQ_READ,   '0,   '0,   4'd15, outcome(1'b0, NO_POS, TOP_H, ONES));
        add_pinned(REQ_NOP,    ONES, ONES, 4'd15, outcome(1'b0, NO_POS, '0, '0));
        add_pinned(REQ_INSERT, TOP_H, ONES, 4'd3, outcome(1'b0, NO_POS, '0, '0));
        add_pinned(REQ_INSERT, BOT_H, '0,  4'd9,  outcome(1'b1, 5'd0, '0, '0));
        add_req(REQ_INSERT, '0,   '0,    4'd0);
        add_req(REQ_INSERT, '0,   '0,    4'd0);
        add_req(REQ_INSERT, ONES, ONES,  4'd0);
        add_req(REQ_INSERT, '0,   ONES,  4'd0);
        add_req(REQ_INSERT, '0,   64'd1, 4'd0);
        add_req(REQ_READ,   ONES, ONES,  4'd1);
        add_req(REQ_READ,   '0,   '0,    4'd2);
        add_pinned(REQ_CLEAR, ONES, ONES, 4'd15, outcome(1'b0, NO_POS, '0, '0));
        add_pinned(REQ_READ,  '0,   '0,   4'd7,  outcome(1'b0, NO_POS, TOP_H, ONES));
        // switch mode without clearing, then descending extremes
        add_cfg(CFG_KEEP_LARGEST, 5'd1);
        add_req(REQ_INSERT, '0, 64'd5, 4'd0);
        add_req(REQ_READ,   '0, '0,    4'd0);
        add_pinned(REQ_CLEAR,  '0,    '0,   4'd0,  outcome(1'b0, NO_POS, '0, '0));
        add_pinned(REQ_READ,   '0,    '0,   4'd3,  outcome(1'b0, NO_POS, BOT_H, '0));
        add_pinned(REQ_INSERT, BOT_H, '0,   4'd0,  outcome(1'b0, NO_POS, '0, '0));
        add_pinned(REQ_INSERT, TOP_H, ONES, 4'd0,  outcome(1'b1, 5'd0, '0, '0));
        add_cfg(CFG_ENTRIES_IN_USE, 5'd0);
        add_pinned(REQ_INSERT, TOP_H, ONES, 4'd0,  outcome(1'b0, NO_POS, '0, '0));
        add_cfg(CFG_ENTRIES_IN_USE, 5'd1);
        add_req(REQ_INSERT, '0, '0, 4'd0);
        add_cfg(CFG_ENTRIES_IN_USE, 5'd31);
        add_req(REQ_INSERT, 64'd7, 64'd7, 4'd0);
        add_req(REQ_INSERT, BOT_H, 64'd1, 4'd0);
        add_cfg(CFG_KEEP_LARGEST, 5'b11110);
        add_cfg(CFG_ENTRIES_IN_USE, 5'd16);
        add_req(REQ_READ, ONES, '0, 4'd15);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(rows[r].reg_ix, rows[r].reg_data);
            end else begin
                send_item(rows[r]);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg / 4)
                0:       begin tx_idle_pct = 17; rx_idle_pct = 79; end
                1:       begin tx_idle_pct = 79; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (seg)
                0:       used = 5'd16;
                1:       used = 5'd1;
                2:       used = 5'($urandom_range(17, 31));
                default: used = ($urandom_range(7) == 0) ? 5'($urandom)
                                                        : 5'($urandom_range(1, 16));
            endcase
            write_reg(CFG_KEEP_LARGEST, {4'($urandom), 1'(seg % 2)});
            write_reg(CFG_ENTRIES_IN_USE, used);
            if ($urandom_range(1)) begin
                it     = random_request();
                it.req = REQ_CLEAR;
                send_item(it);
            end
            // hold the output off while requests keep coming, to fill the block
            if (seg == 9)
                hold_asked++;
            for (n = 0; n < SEG_ITEMS; n++)
                send_item(random_request());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_q.size()));

        $display("requests: %0d inserts placed, %0d rejected, %0d reads, %0d clears, %0d no-ops",
                 n_placed, n_rejected, n_reads, n_clears, n_nops);
        $display("%0d register writes, three idling mixes, %0d output hold-off; %0d failures",
                 n_cfg, hold_served, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
